/* rtl/core/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, request and register codes, character codes and the
// sequencer state type of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default screen geometry.
  localparam int unsigned TCW_ROWS = 25;
  localparam int unsigned TCW_COLS = 80;

  // Field widths of the request and response channels.
  localparam int unsigned REQ_TYPE_W = 3;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CELL_W     = 2 * BYTE_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = BYTE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEFAULT_MARKER = 1'b0,
    CFG_DEFAULT_COLOR  = 1'b1
  } cfg_index_t;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd0;
  localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'd15;

  // Request codes.
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_WRITE_CUR = 3'd0,
    REQ_WRITE_POS = 3'd1,
    REQ_MOVE      = 3'd2,
    REQ_CLEAR     = 3'd3,
    REQ_READ      = 3'd4
  } req_type_t;

  // Character codes with a special meaning.
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_RESP
  } tcw_state_t;

endpackage : tcw_pkg
`default_nettype wire

/* rtl/core/tcw_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console request channel
// Valid/ready channel that carries one console request.
// ----------------------------------------------------------------------------
interface tcw_req_if
  import tcw_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [ROW_W-1:0]      row;
  logic [COL_W-1:0]      column;
  logic [BYTE_W-1:0]     character;
  logic [BYTE_W-1:0]     attribute;

  modport source (
    output valid, req_type, row, column, character, attribute,
    input  ready
  );

  modport sink (
    input  valid, req_type, row, column, character, attribute,
    output ready
  );
endinterface : tcw_req_if
`default_nettype wire

/* rtl/core/tcw_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console response channel
// Valid/ready channel that carries the result of one console request.
// ----------------------------------------------------------------------------
interface tcw_rsp_if
  import tcw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column;
  logic              scrolled;
  logic [BYTE_W-1:0] read_char;
  logic [BYTE_W-1:0] read_attr;

  modport source (
    output valid, cursor_row, cursor_column, scrolled, read_char, read_attr,
    input  ready
  );

  modport sink (
    input  valid, cursor_row, cursor_column, scrolled, read_char, read_attr,
    output ready
  );
endinterface : tcw_rsp_if
`default_nettype wire

/* rtl/core/tcw_screen_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console screen store
// Single write port, single read port cell memory with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem
  import tcw_pkg::*;
#(
  parameter int unsigned DEPTH = TCW_ROWS * TCW_COLS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : tcw_screen_mem
`default_nettype wire

/* rtl/core/text_console_writer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console engine: screen cell store, cursor and request sequencer.
// ----------------------------------------------------------------------------
// A small sequencer serves one request at a time and drives a single
// address/sweep unit in front of a one-write, one-read cell memory. A write,
// read or cursor move passes through accept, address, an execute or memory
// read step where it has one, and response. A clear walks every cell once.
// A write that runs past the last row adds a scroll: the copy sweep moves
// one cell per cycle through the memory port pair, then the bottom row is
// zero-filled. After reset the block zeroes the store in a clearing pass
// and accepts no request until it is done; configuration writes are taken
// at any time. A finished result waits in the output register while the
// next request is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = TCW_ROWS,
  parameter int unsigned COLS = TCW_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tcw_req_if.sink                    in_if,
  tcw_rsp_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLS);
  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [RW:0]   ROWS_X     = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);

  // Sequencer and cursor.
  tcw_state_t state_r, state_nxt;
  logic              init_r,     init_nxt;
  logic [AW-1:0]     sweep_r,    sweep_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic [AW-1:0]     addr_r,     addr_nxt;
  logic [RW-1:0]     cur_row_r,  cur_row_nxt;
  logic [CW-1:0]     cur_col_r,  cur_col_nxt;
  logic              scrolled_r, scrolled_nxt;
  logic              rd_hit_r,   rd_hit_nxt;

  // Captured request.
  logic [REQ_TYPE_W-1:0] req_r,  req_nxt;
  logic [ROW_W-1:0]      row_r,  row_nxt;
  logic [COL_W-1:0]      col_r,  col_nxt;
  logic [BYTE_W-1:0]     ch_r,   ch_nxt;
  logic [BYTE_W-1:0]     attr_r, attr_nxt;

  // Configuration.
  logic [BYTE_W-1:0] marker_r;
  logic [BYTE_W-1:0] color_r;

  // Response register.
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_scr_r;
  logic [BYTE_W-1:0] out_rch_r;
  logic [BYTE_W-1:0] out_rat_r;
  logic              load_out;

  // Memory port.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Shared position terms.
  logic              in_rdy;
  logic              on_screen;
  logic [RW-1:0]     sel_row;
  logic [CW-1:0]     sel_col;
  logic [RW:0]       row_inc;
  logic [BYTE_W-1:0] attr_eff;

  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign on_screen = (32'(row_r) < ROWS) && (32'(col_r) < COLS);
  // A write at the cursor works on the cursor cell, every other request on
  // the row and column it carries.
  assign sel_row  = (req_r == REQ_WRITE_CUR) ? cur_row_r : RW'(row_r);
  assign sel_col  = (req_r == REQ_WRITE_CUR) ? cur_col_r : CW'(col_r);
  assign row_inc  = {1'b0, sel_row} + (RW+1)'(1);
  assign attr_eff = (attr_r == marker_r) ? color_r : attr_r;

  always_comb begin
    logic advance;
    advance       = 1'b0;
    state_nxt     = state_r;
    init_nxt      = init_r;
    sweep_nxt     = sweep_r;
    fill_val_nxt  = fill_val_r;
    addr_nxt      = addr_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    scrolled_nxt  = scrolled_r;
    rd_hit_nxt    = rd_hit_r;
    req_nxt       = req_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ch_nxt        = ch_r;
    attr_nxt      = attr_r;
    in_rdy        = 1'b0;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = fill_val_r;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;

    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_if.valid) begin
          req_nxt      = in_if.req_type;
          row_nxt      = in_if.row;
          col_nxt      = in_if.column;
          ch_nxt       = in_if.character;
          attr_nxt     = in_if.attribute;
          scrolled_nxt = 1'b0;
          rd_hit_nxt   = 1'b0;
          state_nxt    = ST_ADDR;
        end
      end

      ST_ADDR: begin
        addr_nxt = AW'(sel_row) * COLS_A + AW'(sel_col);
        case (req_r)
          REQ_WRITE_CUR: state_nxt = ST_EXEC;
          REQ_WRITE_POS: state_nxt = on_screen ? ST_EXEC : ST_RESP;
          REQ_MOVE: begin
            if (on_screen) begin
              cur_row_nxt = sel_row;
              cur_col_nxt = sel_col;
            end
            state_nxt = ST_RESP;
          end
          REQ_CLEAR: begin
            sweep_nxt    = '0;
            fill_val_nxt = {color_r, CH_SPACE};
            cur_row_nxt  = '0;
            cur_col_nxt  = '0;
            state_nxt    = ST_FILL;
          end
          REQ_READ: state_nxt = on_screen ? ST_READ : ST_RESP;
          default:  state_nxt = ST_RESP;
        endcase
      end

      ST_EXEC: begin
        cur_row_nxt = sel_row;
        cur_col_nxt = '0;
        if (ch_r == CH_NEWLINE) begin
          advance = 1'b1;
        end else if (ch_r != CH_TAB) begin
          mem_we    = 1'b1;
          mem_waddr = addr_r;
          mem_wdata = {attr_eff, ch_r};
          if (sel_col == LAST_COL) begin
            advance = 1'b1;
          end else begin
            cur_col_nxt = sel_col + CW'(1);
          end
        end
        state_nxt = ST_RESP;
        if (advance) begin
          if (row_inc == ROWS_X) begin
            cur_row_nxt  = LAST_ROW;
            scrolled_nxt = 1'b1;
            sweep_nxt    = '0;
            state_nxt    = ST_SCROLL;
          end else begin
            cur_row_nxt = RW'(row_inc);
          end
        end
      end

      ST_READ: begin
        mem_re     = 1'b1;
        mem_raddr  = addr_r;
        rd_hit_nxt = 1'b1;
        state_nxt  = ST_RESP;
      end

      ST_SCROLL: begin
        // Cell sweep_r + COLS is read in this cycle and lands in cell
        // sweep_r in the next, one row up.
        if (sweep_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = sweep_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (sweep_r != SCROLL_END) begin
          mem_re    = 1'b1;
          mem_raddr = sweep_r + COLS_A;
          sweep_nxt = sweep_r + AW'(1);
        end else begin
          fill_val_nxt = '0;
          state_nxt    = ST_FILL;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = fill_val_r;
        if (sweep_r == LAST_CELL) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? ST_IDLE : ST_RESP;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      init_r      <= 1'b1;
      sweep_r     <= '0;
      fill_val_r  <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      scrolled_r  <= 1'b0;
      rd_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      sweep_r     <= sweep_nxt;
      fill_val_r  <= fill_val_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      scrolled_r  <= scrolled_nxt;
      rd_hit_r    <= rd_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    req_r  <= req_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    ch_r   <= ch_nxt;
    attr_r <= attr_nxt;
    if (load_out) begin
      out_row_r <= ROW_W'(cur_row_r);
      out_col_r <= COL_W'(cur_col_r);
      out_scr_r <= scrolled_r;
      out_rch_r <= rd_hit_r ? mem_rdata[BYTE_W-1:0] : '0;
      out_rat_r <= rd_hit_r ? mem_rdata[CELL_W-1:BYTE_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
      color_r  <= COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_MARKER: marker_r <= cfg_wdata;
        CFG_DEFAULT_COLOR:  color_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_if.ready          = in_rdy;
  assign out_if.valid         = out_valid_r;
  assign out_if.cursor_row    = out_row_r;
  assign out_if.cursor_column = out_col_r;
  assign out_if.scrolled      = out_scr_r;
  assign out_if.read_char     = out_rch_r;
  assign out_if.read_attr     = out_rat_r;

endmodule : text_console_writer_unit
`default_nettype wire

/* rtl/core/tcw_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = TCW_ROWS,
  parameter int unsigned COLS = TCW_COLS
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ROW_W-1:0]  cursor_row,
  input wire logic [COL_W-1:0]  cursor_column,
  input wire logic              scrolled,
  input wire logic [BYTE_W-1:0] read_char,
  input wire logic [BYTE_W-1:0] read_attr
);

  // Reset empties the response register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("response valid after reset");

  // The block serves one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // A reported cursor always lies on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(cursor_row) < ROWS) && (32'(cursor_column) < COLS))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && scrolled |->
      (cursor_row == ROW_W'(ROWS - 1)) && (cursor_column == '0))
    else $error("scroll left cursor elsewhere");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cursor_row)
      && $stable(cursor_column) && $stable(scrolled)
      && $stable(read_char) && $stable(read_attr))
    else $error("stalled response changed");

endmodule : tcw_checker

bind text_console_writer_unit tcw_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tcw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .cursor_row    (out_if.cursor_row),
  .cursor_column (out_if.cursor_column),
  .scrolled      (out_if.scrolled),
  .read_char     (out_if.read_char),
  .read_attr     (out_if.read_attr)
);
`default_nettype wire

/* dv/tcw_screen_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console screen checker
// Watches the request, response and configuration ports of the console
// writer. It keeps a shadow screen, cursor and register set, predicts the
// status of every accepted request and compares each response against it.
// ----------------------------------------------------------------------------
module tcw_screen_checker
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_req_if                    req_mon,
  tcw_rsp_if                    rsp_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int unsigned CELLS       = TCW_ROWS * TCW_COLS;
  localparam int          MAX_PRINTED = 100;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic              scrolled;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
  } console_status_t;

  logic [CELL_W-1:0] shadow_screen [CELLS];
  int unsigned       shadow_cursor;
  logic [BYTE_W-1:0] shadow_marker;
  logic [BYTE_W-1:0] shadow_color;
  console_status_t   expected_status_q [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTED) begin
      $display("[%0t] console mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // Puts one character at cell pos of row row_idx and moves the cursor on.
  // Returns 1 when the cursor ran off the screen and the rows moved up.
  function automatic bit place_char(input int unsigned pos, input int unsigned row_idx,
                                    input logic [BYTE_W-1:0] ch,
                                    input logic [BYTE_W-1:0] attr);
    int unsigned       next_cell;
    logic [BYTE_W-1:0] shown_attr;
    shown_attr = (attr == shadow_marker) ? shadow_color : attr;
    if (ch == CH_NEWLINE) begin
      next_cell = (row_idx + 1) * TCW_COLS;
    end else if (ch == CH_TAB) begin
      next_cell = row_idx * TCW_COLS;
    end else begin
      shadow_screen[pos] = {shown_attr, ch};
      next_cell = pos + 1;
    end
    if (next_cell < CELLS) begin
      shadow_cursor = next_cell;
      return 1'b0;
    end
    for (int i = 0; i < CELLS - TCW_COLS; i++) begin
      shadow_screen[i] = shadow_screen[i + TCW_COLS];
    end
    for (int i = CELLS - TCW_COLS; i < CELLS; i++) begin
      shadow_screen[i] = '0;
    end
    shadow_cursor = next_cell - TCW_COLS;
    return 1'b1;
  endfunction

  function automatic console_status_t apply_request(input logic [REQ_TYPE_W-1:0] kind,
                                                    input logic [ROW_W-1:0]      row,
                                                    input logic [COL_W-1:0]      column,
                                                    input logic [BYTE_W-1:0]     ch,
                                                    input logic [BYTE_W-1:0]     attr);
    console_status_t status;
    bit              on_screen;
    int unsigned     pos;
    status    = '0;
    on_screen = (row < TCW_ROWS) && (column < TCW_COLS);
    pos       = row * TCW_COLS + column;
    case (kind)
      REQ_WRITE_CUR: begin
        status.scrolled = place_char(shadow_cursor, shadow_cursor / TCW_COLS, ch, attr);
      end
      REQ_WRITE_POS: begin
        if (on_screen) status.scrolled = place_char(pos, row, ch, attr);
      end
      REQ_MOVE: begin
        if (on_screen) shadow_cursor = pos;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_screen[i] = {shadow_color, CH_SPACE};
        end
        shadow_cursor = 0;
      end
      REQ_READ: begin
        if (on_screen) begin
          status.read_char = shadow_screen[pos][BYTE_W-1:0];
          status.read_attr = shadow_screen[pos][CELL_W-1:BYTE_W];
        end
      end
      default: begin
      end
    endcase
    status.cursor_row    = ROW_W'(shadow_cursor / TCW_COLS);
    status.cursor_column = COL_W'(shadow_cursor % TCW_COLS);
    return status;
  endfunction

  always @(posedge clk) begin
    console_status_t got;
    console_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        shadow_screen[i] = '0;
      end
      shadow_cursor = 0;
      shadow_marker = MARKER_RESET;
      shadow_color  = COLOR_RESET;
      expected_status_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.cursor_row    = rsp_mon.cursor_row;
        got.cursor_column = rsp_mon.cursor_column;
        got.scrolled      = rsp_mon.scrolled;
        got.read_char     = rsp_mon.read_char;
        got.read_attr     = rsp_mon.read_attr;
        if (expected_status_q.size() == 0) begin
          report_mismatch("response arrived with no request outstanding");
        end else begin
          want = expected_status_q.pop_front();
          if (got.cursor_row !== want.cursor_row || got.cursor_column !== want.cursor_column ||
              got.scrolled !== want.scrolled || got.read_char !== want.read_char ||
              got.read_attr !== want.read_attr) begin
            report_mismatch($sformatf(
              "got cur %0d,%0d scr %b rd %h/%h, expected cur %0d,%0d scr %b rd %h/%h",
              got.cursor_row, got.cursor_column, got.scrolled, got.read_char, got.read_attr,
              want.cursor_row, want.cursor_column, want.scrolled, want.read_char,
              want.read_attr));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_status_q.push_back(apply_request(req_mon.req_type, req_mon.row,
                                                  req_mon.column, req_mon.character,
                                                  req_mon.attribute));
      end
      if (cfg_we) begin
        if (cfg_index == CFG_DEFAULT_MARKER) begin
          shadow_marker = cfg_wdata;
        end else if (cfg_index == CFG_DEFAULT_COLOR) begin
          shadow_color = cfg_wdata;
        end
      end
    end
    outstanding <= expected_status_q.size();
  end

endmodule : tcw_screen_checker

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console requests into the writer: a directed opening over cursor
// wrap, scrolling, off-screen positions, unused request codes and clear,
// then random phases under several marker/color settings with random idle
// cycles on both channels, one phase without idling and one long response
// hold-off. The screen checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int          GAP_PERCENT     = 13;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_ITEMS     = 180;
  localparam int          PHASE_COUNT     = 5;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          DRAIN_LIMIT     = 50000;
  localparam int unsigned FIRST_UNUSED_REQ = int'(REQ_READ) + 1;
  localparam int unsigned LAST_UNUSED_REQ  = (1 << REQ_TYPE_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    outstanding;
  bit                    gaps_on = 1'b1;
  int                    hold_off_asked = 0;
  int                    hold_off_served;
  logic [BYTE_W-1:0]     marker_now;
  int unsigned           anchor_row;
  int unsigned           anchor_col;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (req_ch),
    .out_if   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  tcw_screen_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #80_000_000;
    $display("tb failed");
    $finish;
  end

  // Response side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    rsp_ch.ready <= 1'b0;
    hold_off_served = 0;
    forever begin
      @(posedge clk);
      if (hold_off_served < hold_off_asked) begin
        hold_off_served++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
      end
    end
  end

  task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                              input logic [ROW_W-1:0]      row,
                              input logic [COL_W-1:0]      column,
                              input logic [BYTE_W-1:0]     ch,
                              input logic [BYTE_W-1:0]     attr);
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.row       <= row;
    req_ch.column    <= column;
    req_ch.character <= ch;
    req_ch.attribute <= attr;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t reg_sel, input logic [CFG_DATA_W-1:0] reg_value);
    cfg_we    <= 1'b1;
    cfg_index <= reg_sel;
    cfg_wdata <= reg_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (reg_sel == CFG_DEFAULT_MARKER) marker_now = reg_value;
  endtask

  function automatic logic [BYTE_W-1:0] random_character();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return CH_NEWLINE;
    if (roll < 15) return CH_TAB;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [BYTE_W-1:0] random_attribute();
    return ($urandom_range(99) < 20) ? marker_now : BYTE_W'($urandom);
  endfunction

  // Mostly writes and reads; reads favor the area around the last cursor
  // placement so that written cells are actually read back.
  task automatic issue_random_request(output bit counted);
    int unsigned           roll;
    logic [1:0]            off;
    logic [REQ_TYPE_W-1:0] kind;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      column;
    roll    = $urandom_range(99);
    counted = 1'b1;
    row     = ROW_W'($urandom);
    column  = COL_W'($urandom);
    if (roll < 50) begin
      kind = REQ_WRITE_CUR;
    end else if (roll < 60) begin
      kind = REQ_WRITE_POS;
    end else if (roll < 70) begin
      kind = REQ_MOVE;
    end else if (roll < 95) begin
      kind = REQ_READ;
    end else if (roll < 97) begin
      kind = REQ_CLEAR;
      anchor_row = 0;
      anchor_col = 0;
    end else begin
      kind    = REQ_TYPE_W'($urandom_range(FIRST_UNUSED_REQ, LAST_UNUSED_REQ));
      counted = 1'b0;
    end
    if (kind == REQ_WRITE_POS || kind == REQ_MOVE || kind == REQ_READ) begin
      if ($urandom_range(99) < 8) begin
        off    = 2'($urandom_range(1, 3));
        row    = off[0] ? ROW_W'($urandom_range(TCW_ROWS, (1 << ROW_W) - 1))
                        : ROW_W'($urandom_range(0, TCW_ROWS - 1));
        column = off[1] ? COL_W'($urandom_range(TCW_COLS, (1 << COL_W) - 1))
                        : COL_W'($urandom_range(0, TCW_COLS - 1));
      end else if (kind == REQ_READ && $urandom_range(99) < 70) begin
        row    = ROW_W'((anchor_row > 0 && $urandom_range(1) == 1) ? anchor_row - 1
                                                                   : anchor_row);
        column = COL_W'((anchor_col + $urandom_range(0, 20)) % TCW_COLS);
      end else begin
        row    = ROW_W'((kind != REQ_READ && $urandom_range(99) < 30)
                        ? TCW_ROWS - 1 : $urandom_range(0, TCW_ROWS - 1));
        column = COL_W'($urandom_range(0, TCW_COLS - 1));
        if (kind != REQ_READ) begin
          anchor_row = row;
          anchor_col = column;
        end
      end
    end
    send_request(kind, row, column, random_character(), random_attribute());
  endtask

  initial begin
    int unsigned counted_items;
    bit          counted;
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_WRITE_CUR;
    req_ch.row       <= '0;
    req_ch.column    <= '0;
    req_ch.character <= '0;
    req_ch.attribute <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_DEFAULT_MARKER;
    cfg_wdata        <= '0;
    marker_now = MARKER_RESET;
    anchor_row = 0;
    anchor_col = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with the register values from reset.
    send_request(REQ_READ, 0, 0, 8'h00, 8'h00);
    send_request(REQ_WRITE_CUR, 0, 0, 8'h41, MARKER_RESET);
    send_request(REQ_WRITE_CUR, 31, 127, 8'hFF, 8'hFF);
    send_request(REQ_READ, 0, 0, 8'h00, 8'h00);
    send_request(REQ_READ, 0, 1, 8'h00, 8'h00);
    send_request(REQ_WRITE_CUR, 0, 0, CH_NEWLINE, 8'h12);
    send_request(REQ_WRITE_CUR, 0, 0, 8'h78, 8'h34);
    send_request(REQ_WRITE_CUR, 0, 0, CH_TAB, 8'h56);
    // Writing the last cell pushes the cursor off the screen and scrolls.
    send_request(REQ_WRITE_POS, TCW_ROWS - 1, TCW_COLS - 1, 8'h00, 8'h5A);
    send_request(REQ_READ, TCW_ROWS - 2, TCW_COLS - 1, 8'h00, 8'h00);
    send_request(REQ_READ, TCW_ROWS - 1, TCW_COLS - 1, 8'h00, 8'h00);
    send_request(REQ_MOVE, TCW_ROWS - 1, TCW_COLS - 1, 8'h00, 8'h00);
    send_request(REQ_WRITE_CUR, 0, 0, CH_NEWLINE, 8'h00);
    // Off-screen positions leave everything alone.
    send_request(REQ_MOVE, TCW_ROWS, 0, 8'h00, 8'h00);
    send_request(REQ_MOVE, 0, TCW_COLS, 8'h00, 8'h00);
    send_request(REQ_WRITE_POS, 31, 127, 8'h55, 8'hAA);
    send_request(REQ_READ, 31, 127, 8'h00, 8'h00);
    send_request(REQ_MOVE, 0, TCW_COLS - 1, 8'h00, 8'h00);
    send_request(REQ_WRITE_CUR, 0, 0, 8'h7A, 8'h01);
    send_request(REQ_WRITE_POS, 3, 7, CH_NEWLINE, 8'h00);
    send_request(REQ_TYPE_W'(FIRST_UNUSED_REQ), 2, 2, 8'h41, 8'h00);
    send_request(REQ_TYPE_W'(LAST_UNUSED_REQ), 2, 2, 8'h41, 8'h00);
    send_request(REQ_CLEAR, 5, 5, 8'h00, 8'h00);
    send_request(REQ_READ, 10, 40, 8'h00, 8'h00);
    send_request(REQ_WRITE_CUR, 0, 0, CH_TAB, 8'h00);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_register(CFG_DEFAULT_MARKER, 8'hFF);
          write_register(CFG_DEFAULT_COLOR, 8'h00);
        end
        1: begin
          write_register(CFG_DEFAULT_MARKER, 8'h00);
          write_register(CFG_DEFAULT_COLOR, 8'hFF);
        end
        default: begin
          write_register(CFG_DEFAULT_MARKER, BYTE_W'($urandom));
          write_register(CFG_DEFAULT_COLOR, BYTE_W'($urandom));
        end
      endcase
      // One phase runs back to back with no idle cycles on either side.
      gaps_on = (phase != 1);
      counted_items = 0;
      while (counted_items < PHASE_ITEMS) begin
        issue_random_request(counted);
        if (counted) begin
          counted_items++;
          if (phase == 2 && counted_items == 40) hold_off_asked++;
        end
      end
    end
    drain_results();

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule : tb

/* text_console_writer_unit.f */
rtl/core/tcw_pkg.sv
rtl/core/tcw_req_if.sv
rtl/core/tcw_rsp_if.sv
rtl/core/tcw_screen_mem.sv
rtl/core/text_console_writer_unit.sv
rtl/core/tcw_checker.sv
dv/tcw_screen_checker.sv
dv/tb.sv
